FILE: sv/kcl_pkg.sv
// Package of the keypad code lock: key codes, key-to-digit map, result struct.
// No dependencies; used by the interfaces and all modules.
`default_nettype none

package kcl_pkg;

	localparam int KEY_W   = 5;
	localparam int DIGIT_W = 4;
	localparam int CODE_W  = 32;
	localparam int LEN_W   = 4;
	localparam int HELD_W  = 4;

	typedef logic [KEY_W-1:0]   key_t;
	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [LEN_W-1:0]   len_t;

	// Function keys
	localparam key_t KEY_START  = 5'd15;
	localparam key_t KEY_END    = 5'd13;
	localparam key_t KEY_DELETE = 5'd8;

	// Configuration register indexes
	typedef enum logic {
		REG_SECRET_CODE = 1'b0,
		REG_CODE_LENGTH = 1'b1
	} cfg_reg_t;

	localparam code_t SECRET_CODE_RST = 32'h0003_0002;
	localparam len_t  CODE_LENGTH_RST = 4'd6;

	typedef struct packed {
		logic   valid;
		digit_t digit;
	} key_digit_t;

	// Result of one key press
	typedef struct packed {
		key_t              echoed_key;
		logic              unlock;
		logic              wrong_code;
		logic              entry_active;
		logic [HELD_W-1:0] digits_held;
	} kcl_result_t;

	// Keypad layout: ten keys carry the digits, the rest carry none
	function automatic key_digit_t key_digit(input key_t key);
		key_digit_t r;
		r = '{valid: 1'b1, digit: 4'd0};
		case (key)
			5'd14:   r.digit = 4'd0;
			5'd9:    r.digit = 4'd1;
			5'd10:   r.digit = 4'd2;
			5'd11:   r.digit = 4'd3;
			5'd5:    r.digit = 4'd4;
			5'd6:    r.digit = 4'd5;
			5'd7:    r.digit = 4'd6;
			5'd1:    r.digit = 4'd7;
			5'd2:    r.digit = 4'd8;
			5'd3:    r.digit = 4'd9;
			default: r.valid = 1'b0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: sv/kcl_key_if.sv
// Key press channel: valid/ready handshake carrying one key code per item.
// Depends on kcl_pkg.
`default_nettype none

interface kcl_key_if;
	import kcl_pkg::*;

	logic valid;
	logic ready;
	key_t key_code;

	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

`default_nettype wire

FILE: sv/kcl_res_if.sv
// Result channel: valid/ready handshake carrying the outcome of one key press.
// Depends on kcl_pkg.
`default_nettype none

interface kcl_res_if;
	import kcl_pkg::*;

	logic              valid;
	logic              ready;
	key_t              echoed_key;
	logic              unlock;
	logic              wrong_code;
	logic              entry_active;
	logic [HELD_W-1:0] digits_held;

	modport source (output valid, output echoed_key, output unlock, output wrong_code,
		output entry_active, output digits_held, input ready);
	modport sink (input valid, input echoed_key, input unlock, input wrong_code,
		input entry_active, input digits_held, output ready);
endinterface

`default_nettype wire

FILE: sv/kcl_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on kcl_pkg.
`default_nettype none

interface kcl_cfg_if;
	import kcl_pkg::*;

	logic     valid;
	logic     ready;
	cfg_reg_t index;
	code_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/kcl_entry.sv
// Code entry state: entry mode, digit count, digit buffer and parallel code compare.
// Depends on kcl_pkg.
`default_nettype none

module kcl_entry #(
	parameter int MAX_DIGITS = 8
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  kcl_pkg::key_t        key_code,
	input  kcl_pkg::code_t       secret_code,
	input  kcl_pkg::len_t        code_length,
	output kcl_pkg::kcl_result_t result
);
	import kcl_pkg::*;

	localparam int CNT_W = $clog2(MAX_DIGITS + 1);
	localparam int CMP_W = 5;
	localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DIGITS);

	logic             mode_q;
	logic [CNT_W-1:0] cnt_q;
	digit_t           buf_q [MAX_DIGITS];

	logic             mode0, mode_n;
	logic [CNT_W-1:0] cnt0, cnt1, cnt_n;
	logic [CMP_W-1:0] len_c, cl_c, cnt_n_c;
	key_digit_t       kd;
	logic             wr, del, check, match;
	logic [MAX_DIGITS-1:0] mismatch;

	// Effective code length: zero counts as one, capped at the buffer depth
	assign cl_c  = CMP_W'(code_length);
	assign len_c = (cl_c == '0) ? CMP_W'(1) : ((cl_c > MAX_C) ? MAX_C : cl_c);

	// Start/end keys, then digit store or delete
	always_comb begin
		kd    = key_digit(key_code);
		mode0 = (key_code == KEY_START) ? 1'b1 : ((key_code == KEY_END) ? 1'b0 : mode_q);
		cnt0  = (key_code == KEY_START) ? '0 : cnt_q;
		wr    = mode0 && kd.valid && (CMP_W'(cnt0) < MAX_C);
		del   = mode0 && !kd.valid && (key_code == KEY_DELETE) && (cnt0 != '0);
		if (wr) begin
			cnt1 = CNT_W'(cnt0 + 1'b1);
		end else if (del) begin
			cnt1 = CNT_W'(cnt0 - 1'b1);
		end else begin
			cnt1 = cnt0;
		end
		check  = mode0 && (CMP_W'(cnt1) >= len_c);
	end

	// Verdict once the lanes have compared
	assign match  = ~|mismatch;
	assign mode_n = (check && match) ? 1'b0 : mode0;
	assign cnt_n  = check ? '0 : cnt1;

	// One lane per position: buffer cell and its nibble compare
	for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_lane
		logic   hit;
		digit_t cur;
		digit_t ref_nib;

		assign hit = wr && (CMP_W'(cnt0) == CMP_W'(i));
		assign cur = hit ? kd.digit : buf_q[i];

		if (i < 8) begin : g_nib
			assign ref_nib = secret_code[4*i +: 4];
		end else begin : g_zero
			assign ref_nib = '0;
		end

		assign mismatch[i] = (CMP_W'(i) < len_c) && (cur != ref_nib);

		always_ff @(posedge clk) begin
			if (accept && hit) begin
				buf_q[i] <= kd.digit;
			end
		end
	end

	// Entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			cnt_q  <= '0;
		end else if (accept) begin
			mode_q <= mode_n;
			cnt_q  <= cnt_n;
		end
	end

	// Result of the key being accepted
	assign cnt_n_c = CMP_W'(cnt_n);
	always_comb begin
		result.echoed_key   = key_code;
		result.unlock       = check && match;
		result.wrong_code   = check && !match;
		result.entry_active = mode_n;
		result.digits_held  = cnt_n_c[HELD_W-1:0];
	end

	// Checks
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (key_code == KEY_START) |=> mode_q && (cnt_q == '0))
		else $error("start key did not open a clean entry");

	a_unlock_exits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && result.unlock |=> !mode_q && (cnt_q == '0))
		else $error("entry still open after unlock");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) <= MAX_C)
		else $error("digit count beyond buffer depth");

	a_idle_no_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		!mode0 |-> !result.unlock && !result.wrong_code)
		else $error("verdict outside code entry");

endmodule

`default_nettype wire

FILE: sv/keypad_code_lock_top.sv
// Keypad code lock top level: configuration registers, entry logic, result register.
// The result is registered: valid in the cycle after the key item is accepted.
// Throughput: one key item per cycle if results are taken; the register frees when taken.
// Reset: entry off, count zero, secret code 0x00030002, length 6; digit buffer not cleared.
// Depends on kcl_pkg, kcl_key_if, kcl_res_if, kcl_cfg_if, kcl_entry.
`default_nettype none

module keypad_code_lock_top #(
	parameter int MAX_DIGITS = 8
) (
	input wire        clk,
	input wire        arst_n,
	kcl_key_if.sink   key_in,
	kcl_res_if.source res_out,
	kcl_cfg_if.sink   cfg
);
	import kcl_pkg::*;

	code_t       secret_code_q;
	len_t        code_length_q;
	logic        res_valid_q;
	kcl_result_t res_q;
	kcl_result_t res_d;
	logic        accept;

	// Configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			secret_code_q <= SECRET_CODE_RST;
			code_length_q <= CODE_LENGTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SECRET_CODE: secret_code_q <= cfg.data;
				REG_CODE_LENGTH: code_length_q <= cfg.data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Take a key whenever the result register is empty or being drained
	assign key_in.ready = !res_valid_q || res_out.ready;
	assign accept       = key_in.valid && key_in.ready;

	kcl_entry #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_entry (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.key_code    (key_in.key_code),
		.secret_code (secret_code_q),
		.code_length (code_length_q),
		.result      (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (res_out.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign res_out.valid        = res_valid_q;
	assign res_out.echoed_key   = res_q.echoed_key;
	assign res_out.unlock       = res_q.unlock;
	assign res_out.wrong_code   = res_q.wrong_code;
	assign res_out.entry_active = res_q.entry_active;
	assign res_out.digits_held  = res_q.digits_held;

	// Checks
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_out.valid)
		else $error("accepted item produced no result");

	a_empty_takes_key: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid_q |-> key_in.ready)
		else $error("input stalled with empty result register");

	a_result_echo: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res_out.echoed_key == $past(key_in.key_code))
		else $error("echoed key differs from accepted key");

endmodule

`default_nettype wire

FILE: tb/sv/kcl_lock_checker.sv
// Checker for the keypad code lock: watches the key, result and configuration channels,
// predicts the outcome of each key item and compares it with what the lock returns.
// Depends on kcl_pkg, kcl_key_if, kcl_res_if, kcl_cfg_if.
`default_nettype none

module kcl_lock_checker #(
	parameter int MAX_DIGITS = 8
) (
	input wire clk,
	input wire arst_n,
	kcl_key_if key_ch,
	kcl_res_if res_ch,
	kcl_cfg_if cfg_ch,
	output int pending,
	output int errors
);
	import kcl_pkg::*;

	// Shadow of the lock: registers and entry state
	code_t  lock_code;
	len_t   lock_len;
	bit     in_entry;
	int     held;
	digit_t entered [MAX_DIGITS];

	kcl_result_t outcome_q [$];
	int          n_pressed;
	int          n_taken;

	assign pending = n_pressed - n_taken;

	// Keypad layout, -1 for keys that carry no digit
	function automatic int digit_of(input key_t k);
		case (k)
			5'd14:   return 0;
			5'd9:    return 1;
			5'd10:   return 2;
			5'd11:   return 3;
			5'd5:    return 4;
			5'd6:    return 5;
			5'd7:    return 6;
			5'd1:    return 7;
			5'd2:    return 8;
			5'd3:    return 9;
			default: return -1;
		endcase
	endfunction

	// Length in use: zero counts as one, the buffer size caps it
	function automatic int active_len();
		if (lock_len == '0)
			return 1;
		if (int'(lock_len) > MAX_DIGITS)
			return MAX_DIGITS;
		return int'(lock_len);
	endfunction

	// Code digit at a position; positions past the register read as zero
	function automatic int code_digit_at(input int pos);
		if (pos >= 8)
			return 0;
		return int'(lock_code[4*pos +: 4]);
	endfunction

	// Advance the shadow state by one key and return the outcome it gives
	function automatic kcl_result_t next_outcome(input key_t k);
		kcl_result_t r;
		int d;
		int len;
		bit match;
		r = '0;
		if (k == KEY_START) begin
			in_entry = 1'b1;
			held = 0;
		end else if (k == KEY_END) begin
			in_entry = 1'b0;
		end
		if (in_entry) begin
			d = digit_of(k);
			len = active_len();
			if (d >= 0) begin
				// a digit on a full buffer is dropped
				if (held < MAX_DIGITS) begin
					entered[held] = digit_t'(d);
					held++;
				end
			end else if (k == KEY_DELETE && held > 0) begin
				held--;
			end
			// compare over the first len digits once enough are in
			if (held >= len) begin
				match = 1'b1;
				for (int i = 0; i < len; i++)
					if (int'(entered[i]) != code_digit_at(i))
						match = 1'b0;
				held = 0;
				if (match) begin
					r.unlock = 1'b1;
					in_entry = 1'b0;
				end else begin
					r.wrong_code = 1'b1;
				end
			end
		end
		r.echoed_key = k;
		r.entry_active = in_entry;
		r.digits_held = held[HELD_W-1:0];
		return r;
	endfunction

	function automatic int field_diff(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Track the channels at each edge
	always @(posedge clk or negedge arst_n) begin
		kcl_result_t want;
		int bad;
		if (!arst_n) begin
			lock_code = 32'h0003_0002;
			lock_len = 4'd6;
			in_entry = 1'b0;
			held = 0;
			outcome_q.delete();
			n_pressed <= 0;
			n_taken <= 0;
			errors <= 0;
		end else begin
			bad = 0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				if (cfg_ch.index == REG_SECRET_CODE)
					lock_code = cfg_ch.data;
				else
					lock_len = cfg_ch.data[LEN_W-1:0];
			end
			if (res_ch.valid && res_ch.ready) begin
				n_taken <= n_taken + 1;
				if (outcome_q.size() == 0) begin
					$error("result item with key %0d arrived with nothing expected",
						res_ch.echoed_key);
					bad++;
				end else begin
					want = outcome_q.pop_front();
					bad += field_diff("echoed_key", want.echoed_key, res_ch.echoed_key);
					bad += field_diff("unlock", want.unlock, res_ch.unlock);
					bad += field_diff("wrong_code", want.wrong_code, res_ch.wrong_code);
					bad += field_diff("entry_active", want.entry_active, res_ch.entry_active);
					bad += field_diff("digits_held", want.digits_held, res_ch.digits_held);
				end
			end
			if (key_ch.valid && key_ch.ready) begin
				n_pressed <= n_pressed + 1;
				outcome_q.push_back(next_outcome(key_ch.key_code));
			end
			if (bad != 0)
				errors <= errors + bad;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Testbench top for the keypad code lock: clock, reset, key and configuration stimulus,
// result back-pressure, watchdog and verdict. Depends on kcl_pkg, the three channel
// interfaces, keypad_code_lock_top and kcl_lock_checker.
`default_nettype none

module tb_top;
	import kcl_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int RAND_ITEMS  = 900;

	logic clk;
	logic arst_n = 1'b0;

	kcl_key_if key_ch ();
	kcl_res_if res_ch ();
	kcl_cfg_if cfg_ch ();

	int pending;
	int errors;

	// Shared stimulus controls
	bit    hold_req = 1'b0;
	bit    no_idle = 1'b0;
	int    keys_sent = 0;
	code_t cur_code = 32'h0003_0002;
	len_t  cur_len = 4'd6;

	keypad_code_lock_top #(.MAX_DIGITS(8)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_in  (key_ch),
		.res_out (res_ch),
		.cfg     (cfg_ch)
	);

	kcl_lock_checker #(.MAX_DIGITS(8)) chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.key_ch  (key_ch),
		.res_ch  (res_ch),
		.cfg_ch  (cfg_ch),
		.pending (pending),
		.errors  (errors)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Gap lengths: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic key_t key_for_digit(input int d);
		case (d)
			0:       return 5'd14;
			1:       return 5'd9;
			2:       return 5'd10;
			3:       return 5'd11;
			4:       return 5'd5;
			5:       return 5'd6;
			6:       return 5'd7;
			7:       return 5'd1;
			8:       return 5'd2;
			default: return 5'd3;
		endcase
	endfunction

	// A key with no function: neither digit, start, end nor delete
	function automatic key_t noise_key();
		case ($urandom_range(0, 5))
			0:       return 5'd4;
			1:       return 5'd16;
			2:       return 5'd12;
			3:       return 5'd0;
			default: return key_t'($urandom_range(17, 31));
		endcase
	endfunction

	function automatic int eff_len();
		if (cur_len == '0)
			return 1;
		if (cur_len > 4'd8)
			return 8;
		return int'(cur_len);
	endfunction

	task automatic send_key(input key_t k);
		int gap;
		key_ch.valid <= 1'b1;
		key_ch.key_code <= k;
		do @(posedge clk); while (!key_ch.ready);
		keys_sent++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			key_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input code_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		if (idx == REG_SECRET_CODE)
			cur_code = val;
		else
			cur_len = val[LEN_W-1:0];
	endtask

	// Stop offering keys and wait until every result item is back
	task automatic drain();
		key_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// One code attempt: mostly the right digits, some wrong, deletes and noise mixed in
	task automatic code_attempt(input bit abort);
		int n;
		int stop;
		int d;
		send_key(KEY_START);
		n = eff_len();
		stop = abort ? $urandom_range(0, n - 1) : n;
		for (int i = 0; i < n; i++) begin
			if (i == stop) begin
				send_key(KEY_END);
				return;
			end
			if ($urandom_range(0, 9) == 0)
				send_key(noise_key());
			if ($urandom_range(0, 9) == 0) begin
				send_key(key_for_digit($urandom_range(0, 9)));
				send_key(KEY_DELETE);
			end
			d = int'(cur_code[4*i +: 4]);
			if (i >= 8 || d > 9 || $urandom_range(0, 19) == 0)
				d = $urandom_range(0, 9);
			send_key(key_for_digit(d));
		end
	endtask

	// Result side: random back-pressure, one long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int gap;
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (no_idle) begin
				res_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					res_ch.ready <= 1'b1;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end else begin
					res_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: too long without any item moving on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((key_ch.valid && key_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL");
		$finish;
	end

	// Main stimulus
	initial begin
		int target;
		int r;
		len_t  new_len;
		code_t new_code;
		key_ch.valid <= 1'b0;
		key_ch.key_code <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_SECRET_CODE;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset code 2,0,0,0,3,0: key outside the range, delete, then a match
		send_key(5'd0);
		send_key(KEY_START);
		send_key(key_for_digit(2));
		send_key(5'd31);
		send_key(KEY_DELETE);
		send_key(key_for_digit(2));
		send_key(key_for_digit(0));
		send_key(key_for_digit(0));
		send_key(key_for_digit(0));
		send_key(key_for_digit(3));
		send_key(key_for_digit(0));
		drain();

		// Length zero acts as one; nibbles above 9 never match
		write_reg(REG_CODE_LENGTH, 32'd0);
		write_reg(REG_SECRET_CODE, 32'hFFFF_FFF5);
		send_key(KEY_START);
		send_key(KEY_DELETE);
		send_key(key_for_digit(6));
		send_key(key_for_digit(5));
		drain();

		// Length above the buffer size acts as eight; all-zero code
		write_reg(REG_CODE_LENGTH, 32'd15);
		write_reg(REG_SECRET_CODE, 32'h0000_0000);
		send_key(KEY_START);
		repeat (8) send_key(key_for_digit(0));
		drain();

		// Length lowered below the count mid-entry: compare on the next key
		write_reg(REG_CODE_LENGTH, 32'd8);
		write_reg(REG_SECRET_CODE, 32'hFFFF_FFFF);
		send_key(KEY_START);
		send_key(key_for_digit(1));
		send_key(key_for_digit(1));
		drain();
		write_reg(REG_CODE_LENGTH, 32'd1);
		send_key(5'd16);
		send_key(KEY_END);
		drain();

		// Random phases; the first one starts with a long hold-off on the results
		hold_req = 1'b1;
		target = keys_sent + RAND_ITEMS;
		while (keys_sent < target) begin
			r = $urandom_range(0, 9);
			case (r)
				0:       new_len = 4'd1;
				1:       new_len = 4'd8;
				2:       new_len = 4'd0;
				3:       new_len = len_t'($urandom_range(9, 15));
				default: new_len = len_t'($urandom_range(1, 8));
			endcase
			r = $urandom_range(0, 9);
			if (r == 0) begin
				new_code = '0;
			end else if (r == 1) begin
				new_code = '1;
			end else if (r == 2) begin
				new_code = $urandom;
			end else begin
				for (int i = 0; i < 8; i++)
					new_code[4*i +: 4] = digit_t'($urandom_range(0, 9));
			end
			write_reg(REG_CODE_LENGTH, code_t'(new_len));
			write_reg(REG_SECRET_CODE, new_code);
			no_idle = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(4, 10)) begin
				r = $urandom_range(0, 19);
				if (r < 12) begin
					code_attempt(1'b0);
				end else if (r < 15) begin
					code_attempt(1'b1);
				end else begin
					repeat ($urandom_range(3, 8)) begin
						if ($urandom_range(0, 9) == 0)
							send_key(key_t'($urandom_range(0, 31)));
						else
							send_key(key_t'($urandom_range(1, 16)));
					end
				end
			end
			drain();
			no_idle = 1'b0;
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire
